FILE: rtl/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg: shared types and constants of the joystick axis calibrator
// Normalized positions are Q1.15 with +1 = NORM_ONE; drive values are Q.12.
// ----------------------------------------------------------------------------
package jac_pkg;

  localparam int NORM_ONE    = 32768;  // normalized +1.0
  localparam int NORM_SPAN   = 65536;  // normalized 2.0, largest useful quotient
  localparam int NORM_SH     = 16;     // raw difference is scaled by 2^16
  localparam int NORM_W      = 17;     // signed width of a normalized position
  localparam int NORM_Q_W    = 17;     // quotient bits of the normalizing divide
  localparam int WIDE_W      = 18;     // signed width for limits and sums
  localparam int GAIN_W      = 16;     // gain, offset and deadband width
  localparam int PROD_W      = 33;     // gain times shifted position
  localparam int DRV_NUM_W   = 31;     // rounded product magnitude
  localparam int DRV_Q_W     = 16;     // quotient bits of the scaling divide
  localparam int DRV_DEN_W   = 16;     // scaling divisor width
  localparam int DRIVE_W     = 17;     // output drive width
  localparam int DRIVE_MIN   = -65536;
  localparam int DRIVE_MAX   = 65535;

  typedef enum logic [2:0] {
    REGION_CENTRE     = 3'd0,
    REGION_LINEAR     = 3'd1,
    REGION_LOW_SAT    = 3'd2,
    REGION_HIGH_SAT   = 3'd3,
    REGION_ZERO_RANGE = 3'd4
  } region_t;

  typedef enum logic [2:0] {
    CFG_RANGE_LOW       = 3'd0,
    CFG_RANGE_HIGH      = 3'd1,
    CFG_GAIN_FACTOR     = 3'd2,
    CFG_OUTPUT_OFFSET   = 3'd3,
    CFG_CENTRE_DEADBAND = 3'd4,
    CFG_EDGE_DEADBAND   = 3'd5,
    CFG_ALLOW_NEGATIVE  = 3'd6,
    CFG_ALLOW_POSITIVE  = 3'd7
  } cfg_index_t;

endpackage

FILE: rtl/jac_stream_ifs.sv
// ----------------------------------------------------------------------------
// jac_stream_ifs: valid/ready channels of the joystick axis calibrator
// One channel carries raw axis readings in, the other calibrated results out.
// ----------------------------------------------------------------------------
interface jac_in_if #(
  parameter int RAW_WIDTH = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [RAW_WIDTH-1:0] raw_position;

  modport source (output valid, output raw_position, input ready);
  modport sink   (input valid, input raw_position, output ready);
endinterface

interface jac_out_if import jac_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_value;
  region_t                   region;

  modport source (output valid, output drive_value, output region, input ready);
  modport sink   (input valid, input drive_value, input region, output ready);
endinterface

FILE: rtl/joystick_axis_calibrator_unit.sv
// ----------------------------------------------------------------------------
// joystick_axis_calibrator_unit: raw axis reading to calibrated drive value
// Throughput: one item per cycle unless out_ch.ready stalls the pipeline;
// depth is set by the two dividers, one quotient bit per stage
// (17 stages normalizing, 16 stages scaling).
// Reset: synchronous rst_n clears all valid bits and loads register defaults;
// in_ch.ready is registered and rises in the cycle after reset is released.
// ----------------------------------------------------------------------------
module joystick_axis_calibrator_unit import jac_pkg::*; #(
  parameter int RAW_WIDTH = 16,
  localparam int CFG_W = (RAW_WIDTH > GAIN_W) ? RAW_WIDTH : GAIN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  jac_in_if.sink           in_ch,
  jac_out_if.source        out_ch,
  input  logic             cfg_we,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int NUM1_W = RAW_WIDTH + NORM_Q_W;
  localparam logic signed [WIDE_W-1:0] NORM_WIDE = WIDE_W'(NORM_ONE);
  localparam logic signed [WIDE_W-1:0] DRV_LO    = WIDE_W'(DRIVE_MIN);
  localparam logic signed [WIDE_W-1:0] DRV_HI    = WIDE_W'(DRIVE_MAX);

  // Configuration registers and values derived from them.
  logic signed [RAW_WIDTH-1:0] low_r, high_r;
  logic signed [GAIN_W-1:0]    gain_r, offset_r;
  logic [GAIN_W-1:0]           centre_db_r, edge_db_r;
  logic                        allow_neg_r, allow_pos_r;
  logic [RAW_WIDTH:0]          span_full;
  logic [RAW_WIDTH-1:0]        span_mag_r;
  logic                        zero_span_r;
  logic signed [WIDE_W-1:0]    denom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= RAW_WIDTH'(-32'sd32767);
      high_r      <= RAW_WIDTH'(32'sd32767);
      gain_r      <= GAIN_W'(4096);
      offset_r    <= '0;
      centre_db_r <= '0;
      edge_db_r   <= '0;
      allow_neg_r <= 1'b1;
      allow_pos_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_LOW:       low_r       <= cfg_data[RAW_WIDTH-1:0];
        CFG_RANGE_HIGH:      high_r      <= cfg_data[RAW_WIDTH-1:0];
        CFG_GAIN_FACTOR:     gain_r      <= cfg_data[GAIN_W-1:0];
        CFG_OUTPUT_OFFSET:   offset_r    <= cfg_data[GAIN_W-1:0];
        CFG_CENTRE_DEADBAND: centre_db_r <= cfg_data[GAIN_W-1:0];
        CFG_EDGE_DEADBAND:   edge_db_r   <= cfg_data[GAIN_W-1:0];
        CFG_ALLOW_NEGATIVE:  allow_neg_r <= cfg_data[0];
        CFG_ALLOW_POSITIVE:  allow_pos_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign span_full = {high_r[RAW_WIDTH-1], high_r} - {low_r[RAW_WIDTH-1], low_r};

  // Derived values are first used one stage after entry, so registering them is safe.
  always_ff @(posedge clk) begin
    span_mag_r  <= span_full[RAW_WIDTH] ? RAW_WIDTH'(-span_full) : span_full[RAW_WIDTH-1:0];
    zero_span_r <= (span_full == '0);
    denom_r     <= NORM_WIDE - $signed({2'b00, edge_db_r}) - $signed({2'b00, centre_db_r});
  end

  // Output register and global advance.
  logic                      out_v_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  region_t                   out_region_r;
  logic                      adv;

  assign adv = !out_v_r || out_ch.ready;

  // Input skid stage keeps in_ch.ready independent of out_ch.ready.
  logic                        skid_v_r, skid_v_nxt, in_rdy_r, in_acc;
  logic signed [RAW_WIDTH-1:0] skid_raw_r;
  logic                        feed_v;
  logic [RAW_WIDTH-1:0]        feed_raw;

  assign in_acc     = in_ch.valid && in_rdy_r;
  assign skid_v_nxt = skid_v_r ? !adv : (in_acc && !adv);
  assign feed_v     = skid_v_r || in_acc;
  assign feed_raw   = skid_v_r ? skid_raw_r : in_ch.raw_position;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      in_rdy_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
      in_rdy_r <= !skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !adv) begin
      skid_raw_r <= in_ch.raw_position;
    end
  end

  // Stage A: offset from range_low, its magnitude, and the quotient sign.
  logic [RAW_WIDTH:0]   diff;
  logic [RAW_WIDTH-1:0] a_mag_nxt, a_mag_r;
  logic                 a_top_nxt, a_top_r, a_v_r;

  assign diff      = {feed_raw[RAW_WIDTH-1], feed_raw} - {low_r[RAW_WIDTH-1], low_r};
  assign a_mag_nxt = diff[RAW_WIDTH] ? RAW_WIDTH'(-diff) : diff[RAW_WIDTH-1:0];
  // A zero or negative quotient puts the position at or beyond +1.
  assign a_top_nxt = (diff == '0) || (diff[RAW_WIDTH] != span_full[RAW_WIDTH]);

  // Stage B: rounded numerator and quotient overflow test.
  logic [NUM1_W-1:0] b_num_nxt, b_num_r;
  logic              b_ovf_nxt, b_ovf_r, b_top_r, b_v_r;

  assign b_num_nxt = NUM1_W'({a_mag_r, {NORM_SH{1'b0}}}) + NUM1_W'(span_mag_r >> 1);
  assign b_ovf_nxt = RAW_WIDTH'(b_num_nxt >> NORM_Q_W) >= span_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= feed_v;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag_r <= a_mag_nxt;
      a_top_r <= a_top_nxt;
      b_num_r <= b_num_nxt;
      b_ovf_r <= b_ovf_nxt;
      b_top_r <= a_top_r;
    end
  end

  // Normalizing divide.
  logic                d1_v;
  logic [NORM_Q_W-1:0] d1_q;
  logic [1:0]          d1_side;

  jac_div_pipe #(
    .NUM_W  (NUM1_W),
    .DEN_W  (RAW_WIDTH),
    .QUO_W  (NORM_Q_W),
    .SIDE_W (2)
  ) u_norm_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (b_v_r),
    .in_num    (b_num_r),
    .in_side   ({b_top_r, b_ovf_r}),
    .den       (span_mag_r),
    .out_valid (d1_v),
    .out_quo   (d1_q),
    .out_side  (d1_side)
  );

  // Stage C: normalized position, saturated and clamped per half.
  logic [NORM_Q_W-1:0]      q_cap;
  logic signed [WIDE_W-1:0] n_wide;
  logic signed [NORM_W-1:0] n_raw, c_n_nxt, c_n_r;
  logic                     c_v_r;

  assign q_cap  = (d1_side[0] || d1_q > NORM_Q_W'(NORM_SPAN)) ? NORM_Q_W'(NORM_SPAN) : d1_q;
  assign n_wide = NORM_WIDE - $signed({1'b0, q_cap});
  assign n_raw  = d1_side[1] ? NORM_W'(NORM_ONE) : NORM_W'(n_wide);

  always_comb begin
    if (!allow_neg_r && n_raw < 0) begin
      c_n_nxt = '0;
    end else if (!allow_pos_r && n_raw > 0) begin
      c_n_nxt = '0;
    end else begin
      c_n_nxt = n_raw;
    end
  end

  // Stage D: region decision and position measured from the centre deadband.
  logic signed [WIDE_W-1:0] n18, c18, e18, lo_lim, hi_lim, shift18;
  logic [NORM_W-1:0]        mag;
  region_t                  d_region_nxt, d_region_r;
  logic signed [NORM_W-1:0] d_shift_r;
  logic                     d_v_r;

  assign n18     = {c_n_r[NORM_W-1], c_n_r};
  assign c18     = $signed({2'b00, centre_db_r});
  assign e18     = $signed({2'b00, edge_db_r});
  assign mag     = c_n_r[NORM_W-1] ? NORM_W'(-c_n_r) : c_n_r;
  assign lo_lim  = e18 - NORM_WIDE;
  assign hi_lim  = NORM_WIDE - e18;
  assign shift18 = (n18 > 0) ? (n18 - c18) : ((n18 < 0) ? (n18 + c18) : '0);

  always_comb begin
    priority if (mag < NORM_W'(centre_db_r)) begin
      d_region_nxt = REGION_CENTRE;
    end else if (n18 < lo_lim) begin
      d_region_nxt = REGION_LOW_SAT;
    end else if (n18 > hi_lim) begin
      d_region_nxt = REGION_HIGH_SAT;
    end else if (denom_r <= 0) begin
      // Overlapping deadbands leave no slope: the sign picks the rail.
      if (n18 > 0) begin
        d_region_nxt = REGION_HIGH_SAT;
      end else if (n18 < 0) begin
        d_region_nxt = REGION_LOW_SAT;
      end else begin
        d_region_nxt = REGION_CENTRE;
      end
    end else begin
      d_region_nxt = REGION_LINEAR;
    end
  end

  // Stage E: gain times shifted position.
  logic signed [PROD_W-1:0] e_p_nxt, e_p_r;
  region_t                  e_region_r;
  logic                     e_v_r;

  assign e_p_nxt = gain_r * d_shift_r;

  // Stage F: rounded magnitude of the product.
  logic [PROD_W-1:0]    p_abs;
  logic [DRV_NUM_W-1:0] f_num_nxt, f_num_r;
  logic                 f_neg_r;
  region_t              f_region_r;
  logic                 f_v_r;

  assign p_abs     = e_p_r[PROD_W-1] ? PROD_W'(-e_p_r) : e_p_r;
  assign f_num_nxt = DRV_NUM_W'(p_abs) + DRV_NUM_W'(denom_r[DRV_DEN_W-1:0] >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= d1_v;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_n_r      <= c_n_nxt;
      d_region_r <= d_region_nxt;
      d_shift_r  <= NORM_W'(shift18);
      e_p_r      <= e_p_nxt;
      e_region_r <= d_region_r;
      f_num_r    <= f_num_nxt;
      f_neg_r    <= e_p_r[PROD_W-1];
      f_region_r <= e_region_r;
    end
  end

  // Scaling divide.
  logic               d2_v;
  logic [DRV_Q_W-1:0] d2_q;
  logic [3:0]         d2_side;

  jac_div_pipe #(
    .NUM_W  (DRV_NUM_W),
    .DEN_W  (DRV_DEN_W),
    .QUO_W  (DRV_Q_W),
    .SIDE_W (4)
  ) u_scale_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f_v_r),
    .in_num    (f_num_r),
    .in_side   ({f_region_r, f_neg_r}),
    .den       (denom_r[DRV_DEN_W-1:0]),
    .out_valid (d2_v),
    .out_quo   (d2_q),
    .out_side  (d2_side)
  );

  // Final stage: add the offset and saturate into the output register; a zero range gives zero drive.
  region_t                   g_region;
  logic signed [WIDE_W-1:0]  q18, sq18, off18, gain18, sum18;
  logic signed [DRIVE_W-1:0] out_drive_nxt;
  region_t                   out_region_nxt;

  assign g_region = region_t'(d2_side[3:1]);
  assign q18      = $signed({2'b00, d2_q});
  assign sq18     = d2_side[0] ? -q18 : q18;
  assign off18    = {{(WIDE_W-GAIN_W){offset_r[GAIN_W-1]}}, offset_r};
  assign gain18   = {{(WIDE_W-GAIN_W){gain_r[GAIN_W-1]}}, gain_r};

  always_comb begin
    unique case (g_region)
      REGION_CENTRE:   sum18 = off18;
      REGION_LINEAR:   sum18 = off18 + sq18;
      REGION_LOW_SAT:  sum18 = off18 - gain18;
      REGION_HIGH_SAT: sum18 = off18 + gain18;
      default:         sum18 = '0;
    endcase
    if (zero_span_r) begin
      out_drive_nxt  = '0;
      out_region_nxt = REGION_ZERO_RANGE;
    end else begin
      if (sum18 < DRV_LO) begin
        out_drive_nxt = DRIVE_W'(DRV_LO);
      end else if (sum18 > DRV_HI) begin
        out_drive_nxt = DRIVE_W'(DRV_HI);
      end else begin
        out_drive_nxt = DRIVE_W'(sum18);
      end
      out_region_nxt = g_region;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_drive_r  <= out_drive_nxt;
      out_region_r <= out_region_nxt;
    end
  end

  assign in_ch.ready        = in_rdy_r;
  assign out_ch.valid       = out_v_r;
  assign out_ch.drive_value = out_drive_r;
  assign out_ch.region      = out_region_r;

`ifndef NO_ASSERTIONS
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && adv |=> !skid_v_r)
    else $error("skid item was not drained when the pipeline advanced");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !adv |=> skid_v_r && !in_rdy_r)
    else $error("item accepted during a stall was not held in the skid stage");

  a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
    adv && c_v_r |=> d_v_r)
    else $error("valid bit lost between normalize and region stages");

  a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_region_r == REGION_ZERO_RANGE |-> out_drive_r == '0)
    else $error("zero range result carries a nonzero drive value");
`endif

endmodule

FILE: rtl/jac_div_pipe.sv
// ----------------------------------------------------------------------------
// jac_div_pipe: pipelined restoring divider, one quotient bit per stage
// The caller must hold the divisor static while items are in flight; the divider does not enforce it.
// ----------------------------------------------------------------------------
module jac_div_pipe #(
  parameter int NUM_W  = 33,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 17,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [DEN_W-1:0]  den,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [DEN_W-1:0]  rem_r  [QUO_W];
  logic [QUO_W-1:0]  lo_r   [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];
  logic              vld_r  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0]  rem_src;
    logic [QUO_W-1:0]  lo_src;
    logic [SIDE_W-1:0] side_src;
    logic              vld_src;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;

    if (k == 0) begin : g_first
      // The upper numerator bits start as the partial remainder.
      assign rem_src  = DEN_W'(in_num >> QUO_W);
      assign lo_src   = in_num[QUO_W-1:0];
      assign side_src = in_side;
      assign vld_src  = in_valid;
    end else begin : g_rest
      assign rem_src  = rem_r[k-1];
      assign lo_src   = lo_r[k-1];
      assign side_src = side_r[k-1];
      assign vld_src  = vld_r[k-1];
    end

    assign trial   = {rem_src, lo_src[QUO_W-1]};
    assign ge      = trial >= {1'b0, den};
    assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    // Numerator bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        lo_r[k]   <= {lo_src[QUO_W-2:0], ge};
        side_r[k] <= side_src;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = lo_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule
